/* rtl/fpt_pkg.sv */
// Package for the monochrome frame page transposer.
// Holds field widths, item and register codes, reset values and the geometry bundle.
// No dependencies.
package fpt_pkg;

  localparam int FRAME_BYTES_DEFAULT = 1024;

  // Field widths fixed by the item format.
  localparam int ADDR_W  = 10;
  localparam int BYTE_W  = 8;
  localparam int PAGE_W  = 3;
  localparam int COL_W   = 7;
  localparam int LIMIT_W = 11;
  localparam int CFG_W   = 8;
  localparam int IDX_W   = 1;

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [IDX_W-1:0] REG_ROWS    = 1'b1;

  localparam logic [7:0] COLUMNS_RESET = 8'd128;
  localparam logic [6:0] ROWS_RESET    = 7'd16;

  // Active geometry after rounding and clamping.
  typedef struct packed {
    logic [7:0]         cols;   // 8..128
    logic [4:0]         bpr;    // bytes per row, 1..16
    logic [3:0]         pages;  // 1..8
    logic [LIMIT_W-1:0] limit;  // frame size in bytes
  } fpt_geom_t;

endpackage

/* rtl/fpt_in_if.sv */
// Input channel of the frame page transposer: write or fetch items.
// Depends on fpt_pkg.
interface fpt_in_if import fpt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [ADDR_W-1:0]       write_address;
  logic [BYTE_W-1:0]       write_data;

  modport source (output valid, kind, write_address, write_data, input ready);
  modport sink   (input valid, kind, write_address, write_data, output ready);
endinterface

/* rtl/fpt_out_if.sv */
// Output channel of the frame page transposer: display bytes.
// Depends on fpt_pkg.
interface fpt_out_if import fpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] display_byte;
  logic [PAGE_W-1:0] page_index;
  logic [COL_W-1:0]  column_index;
  logic              last;

  modport source (output valid, display_byte, page_index, column_index, last, input ready);
  modport sink   (input valid, display_byte, page_index, column_index, last, output ready);
endinterface

/* rtl/fpt_store.sv */
// Frame store: single write port, single read port, registered read data.
// Depends on fpt_pkg.
module fpt_store import fpt_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT,
  localparam int AW = $clog2(FRAME_BYTES)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/fpt_ctrl.sv */
// Sequencer of the frame page transposer: clearing pass, byte writes, eight-read
// gather of one display byte, page/column counters and the output register.
// Depends on fpt_pkg, fpt_in_if and fpt_out_if.
module fpt_ctrl import fpt_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT,
  localparam int AW = $clog2(FRAME_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  fpt_geom_t         geom,
  fpt_in_if.sink            item,
  fpt_out_if.source         result,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [BYTE_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [BYTE_W-1:0] mem_rdata
);

  typedef enum logic [2:0] {CLEAR, IDLE, GATHER, COLLECT, FINISH} state_t;

  state_t             state;
  logic [AW-1:0]      clr_addr;
  logic [2:0]         row_sel;
  logic               pend;
  logic [2:0]         pend_row;
  logic               pend_ok;
  logic [BYTE_W-1:0]  acc;
  logic [PAGE_W-1:0]  page_counter;
  logic [COL_W-1:0]   column_counter;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic [PAGE_W-1:0]  out_page;
  logic [COL_W-1:0]   out_col;
  logic               out_last;

  logic               accept;
  logic               write_ok;
  logic [5:0]         row;
  logic [LIMIT_W-1:0] rd_addr;
  logic               rd_ok;
  logic               pix;
  logic               col_end;
  logic               page_end;
  logic               out_free;

  assign accept   = item.valid && item.ready;
  assign write_ok = {1'b0, item.write_address} < geom.limit;

  // Row-major address of row (8*page + row_sel) at the current column's byte.
  assign row     = {page_counter, row_sel};
  assign rd_addr = LIMIT_W'(row) * LIMIT_W'(geom.bpr) + LIMIT_W'(column_counter[COL_W-1:3]);
  assign rd_ok   = rd_addr < geom.limit;

  assign pix      = mem_rdata[column_counter[2:0]] & pend_ok;
  assign col_end  = {1'b0, column_counter} >= geom.cols - 8'd1;
  assign page_end = {1'b0, page_counter} >= geom.pages - 4'd1;
  assign out_free = !out_valid || result.ready;

  assign item.ready = (state == IDLE);

  always_comb begin
    if (state == CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = accept && (item.kind == KIND_WRITE) && write_ok;
      mem_waddr = item.write_address[AW-1:0];
      mem_wdata = item.write_data;
    end
  end

  assign mem_re    = (state == GATHER);
  assign mem_raddr = rd_addr[AW-1:0];

  assign result.valid        = out_valid;
  assign result.display_byte = out_byte;
  assign result.page_index   = out_page;
  assign result.column_index = out_col;
  assign result.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= CLEAR;
      clr_addr       <= '0;
      row_sel        <= '0;
      pend           <= 1'b0;
      page_counter   <= '0;
      column_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      // Read data lands in the cycle after the address; fold it into the byte.
      if (pend) begin
        acc[pend_row] <= pix;
      end
      pend <= (state == GATHER);

      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(FRAME_BYTES - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept && item.kind == KIND_FETCH) begin
            row_sel <= '0;
            state   <= GATHER;
          end
        end
        GATHER: begin
          pend_row <= row_sel;
          pend_ok  <= rd_ok;
          row_sel  <= row_sel + 3'd1;
          if (row_sel == 3'd7) begin
            state <= COLLECT;
          end
        end
        COLLECT: begin
          state <= FINISH;
        end
        FINISH: begin
          if (out_free) begin
            out_byte  <= acc;
            out_page  <= page_counter;
            out_col   <= column_counter;
            out_last  <= col_end && page_end;
            if (col_end) begin
              column_counter <= '0;
              page_counter   <= page_end ? '0 : page_counter + 3'd1;
            end else begin
              column_counter <= column_counter + 7'd1;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/mono_frame_page_transposer.sv */
// Top level of the monochrome frame page transposer.
// Holds the geometry registers and joins fpt_ctrl to fpt_store; depends on fpt_pkg,
// fpt_in_if, fpt_out_if, fpt_ctrl and fpt_store.
//
//   Channel   Direction  Transfer when         Payload
//   item      in         valid and ready       kind, write_address, write_data
//   result    out        valid and ready       display_byte, page_index, column_index, last
//   cfg       in         cfg_write high        cfg_index, cfg_data
//
// A write item is stored in the cycle it is taken. A fetch steps through GATHER,
// COLLECT and FINISH to the result register, and no item is taken until it is back
// in IDLE: eight reads through the frame store's one read port, one per pixel row.
// After reset a clearing pass zeroes the store with item.ready low.
// A result waiting in the output register holds only the end of the next fetch;
// writes are still taken meanwhile while no fetch is in progress.
module mono_frame_page_transposer import fpt_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  fpt_in_if.sink           item,
  fpt_out_if.source        result
);

  localparam int AW = $clog2(FRAME_BYTES);

  logic [7:0]         columns;
  logic [6:0]         rows;
  logic [7:0]         cols_masked;
  logic [6:0]         rows_masked;
  logic [7:0]         act_cols;
  logic [6:0]         act_rows;
  logic [8:0]         page_bytes;
  logic [LIMIT_W-1:0] frame_size;
  fpt_geom_t          geom;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [BYTE_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [BYTE_W-1:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= COLUMNS_RESET;
      rows    <= ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLUMNS: columns <= cfg_data;
        REG_ROWS:    rows    <= cfg_data[6:0];
        default:     ;
      endcase
    end
  end

  // Round down to a multiple of eight, then hold within the panel limits.
  assign cols_masked = columns & 8'hF8;
  assign rows_masked = rows & 7'h78;
  assign act_cols = (cols_masked == 8'd0)   ? 8'd8   :
                    (cols_masked > 8'd128)  ? 8'd128 : cols_masked;
  assign act_rows = (rows_masked == 7'd0)   ? 7'd8   :
                    (rows_masked > 7'd64)   ? 7'd64  : rows_masked;

  assign page_bytes = 9'(act_cols[7:3]) * 9'(act_rows[6:3]);
  assign frame_size = {page_bytes[7:0], 3'b000};

  assign geom.cols  = act_cols;
  assign geom.bpr   = act_cols[7:3];
  assign geom.pages = act_rows[6:3];
  assign geom.limit = (frame_size > LIMIT_W'(FRAME_BYTES)) ? LIMIT_W'(FRAME_BYTES)
                                                          : frame_size;

  fpt_ctrl #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .item      (item),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fpt_store #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
